// ----- rtl/core/twmv_pkg.sv -----
// shared widths, defaults and state codes for the time-weighted mean and variance block
`timescale 1ns / 1ps

package twmv_pkg;

  // defaults for the top-level parameters
  localparam int ENTRY_COUNT_DEF = 64;
  localparam int COUNT_BITS_DEF  = 16;

  // fixed field widths
  localparam int IDX_W    = 6;
  localparam int CNT_IN_W = 16;
  localparam int TIME_W   = 32;
  localparam int MEAN_W   = 32;
  localparam int VAR_W    = 48;

  // q1.16 weights run 0..65536, so they need one bit above the fraction
  localparam int FRAC_BITS = 16;
  localparam int W_BITS    = FRAC_BITS + 1;
  localparam logic [W_BITS-1:0] ONE_Q16 = W_BITS'(1) << FRAC_BITS;

  // multiplier digit, bits of the serial operand taken per cycle
  localparam int DIGIT_BITS = 4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DIV,
    S_WSTART,
    S_WMUL,
    S_MEAN,
    S_NSQ,
    S_VAR,
    S_FIN
  } state_t;

endpackage

// ----- rtl/core/twmv_if.sv -----
// valid/ready channels for input words and result words
`timescale 1ns / 1ps

interface twmv_in_if;
  import twmv_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    entry_index;
  logic [CNT_IN_W-1:0] sample_count;
  logic [TIME_W-1:0]   elapsed_before;
  logic [TIME_W-1:0]   time_step;

  modport source (output valid, entry_index, sample_count, elapsed_before, time_step,
                  input ready);
  modport sink   (input valid, entry_index, sample_count, elapsed_before, time_step,
                  output ready);
endinterface

interface twmv_out_if;
  import twmv_pkg::*;

  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] new_mean;
  logic [VAR_W-1:0]  new_variance;
  logic              zero_time;

  modport source (output valid, new_mean, new_variance, zero_time, input ready);
  modport sink   (input valid, new_mean, new_variance, zero_time, output ready);
endinterface

// ----- rtl/core/twmv_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module twmv_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/twmv_smul.sv -----
// digit-serial unsigned multiplier, one digit of b per cycle
`timescale 1ns / 1ps

module twmv_smul #(
  parameter int A_BITS     = 32,
  parameter int B_BITS     = 17,
  parameter int DIGIT_BITS = twmv_pkg::DIGIT_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic                     busy,
  output logic [A_BITS+B_BITS-1:0] product
);

  localparam int STEPS = (B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BW    = STEPS * DIGIT_BITS;
  localparam int PW    = A_BITS + BW;
  localparam int SW    = A_BITS + DIGIT_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [A_BITS-1:0] a_q;
  logic [BW-1:0]     b_sh;
  logic [PW-1:0]     acc;
  logic [PW-1:0]     acc_next;
  logic [CNT_W-1:0]  step_cnt;
  logic [SW-1:0]     partial;
  logic [SW-1:0]     sum;

  always_comb begin
    partial  = SW'(a_q) * SW'(b_sh[DIGIT_BITS-1:0]);
    sum      = SW'(acc[PW-1:BW]) + partial;
    // accumulate at the top, shift the finished low digit down
    acc_next = PW'({sum, acc[BW-1:0]} >> DIGIT_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      step_cnt <= CNT_W'(STEPS);
    end else if (busy) begin
      step_cnt <= step_cnt - CNT_W'(1);
      if (step_cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      b_sh <= BW'(b);
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= b_sh >> DIGIT_BITS;
    end
  end

  assign product = acc[A_BITS+B_BITS-1:0];

endmodule

// ----- rtl/core/time_weighted_mean_variance.sv -----
// time-weighted running mean and variance per entry, digit-serial datapath
// an update gives its result once the 17-step radix-2 weight divider and the 4-bit digit
// multipliers have run; the next word is taken once the result is in the output register,
// which waits while a result there is unread. zero total time or an index past the store
// skips the divider and multipliers. synchronous reset clears control, then a clearing
// pass zeroes the store, one entry a cycle, before the first word is accepted
`timescale 1ns / 1ps

module time_weighted_mean_variance #(
  parameter int ENTRY_COUNT = twmv_pkg::ENTRY_COUNT_DEF,
  parameter int COUNT_BITS  = twmv_pkg::COUNT_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  twmv_in_if.sink  sample_in,
  twmv_out_if.source result_out
);
  import twmv_pkg::*;

  localparam int ADDR_W    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CNT_W     = (COUNT_BITS < CNT_IN_W) ? COUNT_BITS : CNT_IN_W;
  localparam int CSQ_W     = 2 * CNT_W;
  localparam int M2_W      = VAR_W + 1;
  localparam int SQ_W      = 2 * MEAN_W;
  localparam int SQR_W     = SQ_W - FRAC_BITS;
  localparam int MW_W      = MEAN_W + W_BITS;
  localparam int CW_W      = CNT_W + W_BITS;
  localparam int M2W_W     = M2_W + W_BITS;
  localparam int C2W_W     = CSQ_W + W_BITS;
  localparam int TOTAL_W   = TIME_W + 1;
  localparam int NUM_W     = TIME_W + FRAC_BITS + 1;
  localparam int NM_W      = MW_W - FRAC_BITS + 1;
  localparam int SUM_W     = M2W_W - FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(W_BITS + 1);
  localparam int ST_W      = MEAN_W + VAR_W;

  state_t state;
  state_t state_next;

  // accepted word
  logic [IDX_W-1:0]   idx_q;
  logic               idx_ok_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [TIME_W-1:0]  step_q;
  logic [TOTAL_W-1:0] total_q;

  // stored entry
  logic [MEAN_W-1:0] mean_q;
  logic [VAR_W-1:0]  var_q;

  // divider
  logic [TOTAL_W-1:0]   div_rem;
  logic [W_BITS-1:0]    div_sh;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TOTAL_W:0]     div_trial;
  logic                 div_ge;
  logic [TOTAL_W-1:0]   div_rem_next;
  logic [NUM_W-1:0]     div_num;
  logic                 div_exit;

  logic [W_BITS-1:0] w_prev;

  // intermediate results
  logic [M2_W-1:0]   m2_q;
  logic [NM_W-1:0]   nmean_full;
  logic [MEAN_W-1:0] nmean_sat;
  logic [MEAN_W-1:0] nmean_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  sum_calc;
  logic [SQR_W-1:0]  sqr_q;
  logic [SUM_W-1:0]  var_diff;
  logic [VAR_W-1:0]  var_calc;

  // result waiting for the output stage
  logic [MEAN_W-1:0] res_mean;
  logic [VAR_W-1:0]  res_var;
  logic              res_zero;
  logic              res_write;

  // output register
  logic              out_valid;
  logic [MEAN_W-1:0] out_mean;
  logic [VAR_W-1:0]  out_var;
  logic              out_zero;
  logic              out_load;

  // clearing pass
  logic [ADDR_W-1:0] clr_addr;

  // store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ST_W-1:0]   ram_wdata;
  logic [ST_W-1:0]   ram_rdata;
  logic [MEAN_W-1:0] rd_mean;
  logic [VAR_W-1:0]  rd_var;

  // multipliers
  logic              sq_start;
  logic              csq_start;
  logic              wmul_start;
  logic [MEAN_W-1:0] sq_a;
  logic              sq_busy;
  logic              csq_busy;
  logic              mw_busy;
  logic              cw_busy;
  logic              m2w_busy;
  logic              c2w_busy;
  logic [SQ_W-1:0]   sq_prod;
  logic [CSQ_W-1:0]  csq_prod;
  logic [MW_W-1:0]   mw_prod;
  logic [CW_W-1:0]   cw_prod;
  logic [M2W_W-1:0]  m2w_prod;
  logic [C2W_W-1:0]  c2w_prod;

  assign rd_mean = ram_rdata[MEAN_W-1:0];
  assign rd_var  = ram_rdata[ST_W-1:MEAN_W];

  twmv_ram #(
    .WIDTH (ST_W),
    .DEPTH (ENTRY_COUNT),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ADDR_W'(sample_in.entry_index)),
    .rdata(ram_rdata)
  );

  // mean squared, later reused for the new mean squared
  twmv_smul #(.A_BITS(MEAN_W), .B_BITS(MEAN_W)) u_sq (
    .clk(clk), .rst(rst), .start(sq_start), .a(sq_a), .b(sq_a),
    .busy(sq_busy), .product(sq_prod)
  );

  twmv_smul #(.A_BITS(CNT_W), .B_BITS(CNT_W)) u_csq (
    .clk(clk), .rst(rst), .start(csq_start), .a(cnt_q), .b(cnt_q),
    .busy(csq_busy), .product(csq_prod)
  );

  twmv_smul #(.A_BITS(MEAN_W), .B_BITS(W_BITS)) u_mw (
    .clk(clk), .rst(rst), .start(wmul_start), .a(mean_q), .b(w_prev),
    .busy(mw_busy), .product(mw_prod)
  );

  twmv_smul #(.A_BITS(CNT_W), .B_BITS(W_BITS)) u_cw (
    .clk(clk), .rst(rst), .start(wmul_start), .a(cnt_q), .b(div_sh),
    .busy(cw_busy), .product(cw_prod)
  );

  twmv_smul #(.A_BITS(M2_W), .B_BITS(W_BITS)) u_m2w (
    .clk(clk), .rst(rst), .start(wmul_start), .a(m2_q), .b(w_prev),
    .busy(m2w_busy), .product(m2w_prod)
  );

  twmv_smul #(.A_BITS(CSQ_W), .B_BITS(W_BITS)) u_c2w (
    .clk(clk), .rst(rst), .start(wmul_start), .a(csq_prod), .b(div_sh),
    .busy(c2w_busy), .product(c2w_prod)
  );

  // arithmetic between the serial units
  always_comb begin
    div_trial    = {div_rem, div_sh[W_BITS-1]};
    div_ge       = div_trial >= (TOTAL_W + 1)'(total_q);
    div_rem_next = TOTAL_W'(div_ge ? div_trial - (TOTAL_W + 1)'(total_q) : div_trial);
    // step in q16 plus half the total, so the quotient rounds ties up
    div_num      = NUM_W'({step_q, FRAC_BITS'(0)}) + NUM_W'(total_q[TOTAL_W-1:1]);
    div_exit     = (div_cnt == '0) && !sq_busy && !csq_busy;

    w_prev = ONE_Q16 - div_sh;

    nmean_full = NM_W'(mw_prod[MW_W-1:FRAC_BITS]) + NM_W'(cw_prod)
               + NM_W'(mw_prod[FRAC_BITS-1]);
    nmean_sat  = (|nmean_full[NM_W-1:MEAN_W]) ? '1 : nmean_full[MEAN_W-1:0];

    sum_calc = SUM_W'(m2w_prod[M2W_W-1:FRAC_BITS]) + SUM_W'(c2w_prod)
             + SUM_W'(m2w_prod[FRAC_BITS-1]);

    var_diff = sum_q - SUM_W'(sqr_q);
    if (sum_q > SUM_W'(sqr_q)) begin
      var_calc = (|var_diff[SUM_W-1:VAR_W]) ? '1 : var_diff[VAR_W-1:0];
    end else begin
      var_calc = '0;
    end

    sq_a = (state == S_MEAN) ? nmean_sat : rd_mean;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(ENTRY_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (sample_in.valid) state_next = S_READ;
      end
      S_READ: begin
        if (!idx_ok_q || (total_q == '0)) state_next = S_FIN;
        else                              state_next = S_DIV;
      end
      S_DIV: begin
        if (div_exit) state_next = S_WSTART;
      end
      S_WSTART: state_next = S_WMUL;
      S_WMUL: begin
        if (!mw_busy && !cw_busy && !m2w_busy && !c2w_busy) state_next = S_MEAN;
      end
      S_MEAN: state_next = S_NSQ;
      S_NSQ: begin
        if (!sq_busy) state_next = S_VAR;
      end
      S_VAR: state_next = S_FIN;
      S_FIN: begin
        if (!out_valid || result_out.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    sample_in.ready = 1'b0;
    sq_start        = 1'b0;
    csq_start       = 1'b0;
    wmul_start      = 1'b0;
    out_load        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = ADDR_W'(idx_q);
    ram_wdata       = {res_var, res_mean};
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: sample_in.ready = 1'b1;
      S_READ: begin
        if (idx_ok_q && (total_q != '0)) begin
          sq_start  = 1'b1;
          csq_start = 1'b1;
        end
      end
      S_WSTART: wmul_start = 1'b1;
      S_MEAN:   sq_start   = 1'b1;
      S_FIN: begin
        if (!out_valid || result_out.ready) begin
          out_load = 1'b1;
          ram_we   = res_write;
        end
      end
      S_DIV, S_WMUL, S_NSQ, S_VAR: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == S_READ) begin
        div_cnt <= DIV_CNT_W'(W_BITS);
      end else if ((state == S_DIV) && (div_cnt != '0)) begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      idx_q    <= sample_in.entry_index;
      idx_ok_q <= int'(sample_in.entry_index) < ENTRY_COUNT;
      cnt_q    <= sample_in.sample_count[CNT_W-1:0];
      step_q   <= sample_in.time_step;
      total_q  <= TOTAL_W'(sample_in.elapsed_before) + TOTAL_W'(sample_in.time_step);
    end

    if (state == S_READ) begin
      mean_q  <= rd_mean;
      var_q   <= rd_var;
      div_rem <= TOTAL_W'(div_num[NUM_W-1:W_BITS]);
      div_sh  <= div_num[W_BITS-1:0];
      res_write <= 1'b0;
      if (!idx_ok_q) begin
        res_mean <= '0;
        res_var  <= '0;
        res_zero <= 1'b0;
      end else begin
        // zero total time hands back the stored entry untouched
        res_mean <= rd_mean;
        res_var  <= rd_var;
        res_zero <= 1'b1;
      end
    end

    if ((state == S_DIV) && (div_cnt != '0)) begin
      div_rem <= div_rem_next;
      div_sh  <= {div_sh[W_BITS-2:0], div_ge};
    end

    if ((state == S_DIV) && div_exit) begin
      m2_q <= M2_W'(var_q) + M2_W'(sq_prod[SQ_W-1:FRAC_BITS]) + M2_W'(sq_prod[FRAC_BITS-1]);
    end

    if (state == S_MEAN) begin
      nmean_q <= nmean_sat;
      sum_q   <= sum_calc;
    end

    if ((state == S_NSQ) && !sq_busy) begin
      sqr_q <= SQR_W'(sq_prod[SQ_W-1:FRAC_BITS]) + SQR_W'(sq_prod[FRAC_BITS-1]);
    end

    if (state == S_VAR) begin
      res_mean  <= nmean_q;
      res_var   <= var_calc;
      res_zero  <= 1'b0;
      res_write <= 1'b1;
    end

    if (out_load) begin
      out_mean <= res_mean;
      out_var  <= res_var;
      out_zero <= res_zero;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.new_mean     = out_mean;
  assign result_out.new_variance = out_var;
  assign result_out.zero_time    = out_zero;

  // store is only written by the clearing pass and on completing an update
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_FIN))
    else $error("store written outside clearing pass or completion");

  // rounded weight can never exceed one
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WSTART) |-> (div_sh <= ONE_Q16))
    else $error("step weight above one");

  // the four weight multipliers run in lockstep
  a_wmul_lockstep: assert property (@(posedge clk) disable iff (rst)
    (state == S_WMUL) |-> (mw_busy == cw_busy && cw_busy == m2w_busy &&
                           m2w_busy == c2w_busy))
    else $error("weight multipliers out of step");

  // a waiting result is held until the output register frees
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !result_out.ready) |=> (state == S_FIN && out_valid))
    else $error("result word lost while output stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (state == S_CLEAR && clr_addr == '0))
    else $error("reset did not restart the clearing pass");

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the time-weighted mean and variance block
`timescale 1ns / 1ps

module tb_top;
  import twmv_pkg::*;

  localparam int ENTRIES      = ENTRY_COUNT_DEF;
  localparam int COUNT_W      = COUNT_BITS_DEF;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic              zero_time;
  } stat_word_t;

  class mean_var_scoreboard;
    bit [MEAN_W-1:0] mean_mem[ENTRIES];
    bit [VAR_W-1:0]  var_mem[ENTRIES];
    stat_word_t      expected_q[$];
    int              faults;
    int              samples;
    int              checked;
    int              zero_hits;

    // running stats update for one accepted word, queues the result it must give
    task note_sample(bit [IDX_W-1:0] idx, bit [CNT_IN_W-1:0] cnt_in,
                     bit [TIME_W-1:0] elapsed, bit [TIME_W-1:0] step);
      bit [63:0]  cnt, total, w_new, w_prev, mean_old, var_old, acc, mean_next;
      bit [63:0]  m2, term1, term2, acc_var, sq, var_next;
      stat_word_t word;
      samples++;
      word = '{mean: '0, variance: '0, zero_time: 1'b0};
      cnt = 64'(cnt_in) & ((64'd1 << COUNT_W) - 64'd1);
      total = 64'(elapsed) + 64'(step);
      if (idx < ENTRIES) begin
        mean_old = 64'(mean_mem[idx]);
        var_old  = 64'(var_mem[idx]);
        if (total == 0) begin
          word = '{mean: mean_old[MEAN_W-1:0], variance: var_old[VAR_W-1:0], zero_time: 1'b1};
        end else begin
          w_new = ((64'(step) << FRAC_BITS) + (total >> 1)) / total;
          if (w_new > 64'(ONE_Q16)) w_new = 64'(ONE_Q16);
          w_prev = 64'(ONE_Q16) - w_new;
          acc = mean_old * w_prev + (cnt << FRAC_BITS) * w_new;
          mean_next = (acc + 64'h8000) >> FRAC_BITS;
          if (mean_next > 64'hFFFF_FFFF) mean_next = 64'hFFFF_FFFF;
          m2 = var_old + ((mean_old * mean_old + 64'h8000) >> FRAC_BITS);
          // split multiply keeps the rounding of the low half exact
          term1 = (m2 >> FRAC_BITS) * w_prev
                + (((m2 & 64'hFFFF) * w_prev + 64'h8000) >> FRAC_BITS);
          term2 = cnt * cnt * w_new;
          if (term2 > ~64'd0 - term1) acc_var = ~64'd0;
          else acc_var = term1 + term2;
          sq = (mean_next * mean_next + 64'h8000) >> FRAC_BITS;
          var_next = (acc_var > sq) ? acc_var - sq : 64'd0;
          if (var_next > 64'hFFFF_FFFF_FFFF) var_next = 64'hFFFF_FFFF_FFFF;
          mean_mem[idx] = mean_next[MEAN_W-1:0];
          var_mem[idx]  = var_next[VAR_W-1:0];
          word = '{mean: mean_next[MEAN_W-1:0], variance: var_next[VAR_W-1:0], zero_time: 1'b0};
        end
      end
      expected_q.insert(expected_q.size(), word);
    endtask

    task report_fault(string msg);
      faults++;
      if (faults <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [MEAN_W-1:0] mean, logic [VAR_W-1:0] variance, logic zero_time);
      stat_word_t exp_word;
      if (expected_q.size() == 0) begin
        report_fault($sformatf("result word with nothing outstanding, mean %h", mean));
      end else begin
        exp_word = expected_q.pop_front();
        checked++;
        if (exp_word.zero_time) zero_hits++;
        if (mean !== exp_word.mean)
          report_fault($sformatf("word %0d new_mean %h, want %h", checked, mean, exp_word.mean));
        if (variance !== exp_word.variance)
          report_fault($sformatf("word %0d new_variance %h, want %h", checked, variance,
                                 exp_word.variance));
        if (zero_time !== exp_word.zero_time)
          report_fault($sformatf("word %0d zero_time %b, want %b", checked, zero_time,
                                 exp_word.zero_time));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  twmv_in_if  sample_if ();
  twmv_out_if result_if ();

  time_weighted_mean_variance u_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_if),
    .result_out (result_if)
  );

  mean_var_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int holds_done;
  int hold_left;
  int directed_items;

  bit [TIME_W-1:0]   clock_of[ENTRIES];
  bit [CNT_IN_W-1:0] level_of[ENTRIES];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side, with its own count of held-off cycles
  initial begin
    result_if.ready <= 1'b0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && sample_if.valid && sample_if.ready)
      sb.note_sample(sample_if.entry_index, sample_if.sample_count,
                     sample_if.elapsed_before, sample_if.time_step);
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      sb.check_result(result_if.new_mean, result_if.new_variance, result_if.zero_time);
  end

  task send_sample(bit [IDX_W-1:0] idx, bit [CNT_IN_W-1:0] cnt,
                   bit [TIME_W-1:0] elapsed, bit [TIME_W-1:0] step);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid          <= 1'b1;
    sample_if.entry_index    <= idx;
    sample_if.sample_count   <= cnt;
    sample_if.elapsed_before <= elapsed;
    sample_if.time_step      <= step;
    do @(posedge clk); while (!sample_if.ready);
  endtask

  task run_directed();
    // zero total time on an untouched entry
    send_sample(6'd0, 16'd0, 32'd0, 32'd0);
    // whole weight on the new step, then half and half, then none
    send_sample(6'd0, 16'd10, 32'd0, 32'h0001_0000);
    send_sample(6'd0, 16'd20, 32'h0001_0000, 32'h0001_0000);
    send_sample(6'd0, 16'd0, 32'h0002_0000, 32'd0);
    // zero total time now hands back the stored stats
    send_sample(6'd0, 16'hFFFF, 32'd0, 32'd0);
    // widest count and times
    send_sample(6'd63, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
    send_sample(6'd63, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(6'd63, 16'hFFFF, 32'hFFFF_FFFF, 32'd1);
    send_sample(6'd63, 16'd0, 32'd1, 32'hFFFF_FFFF);
    send_sample(6'd63, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // alternating bit patterns
    send_sample(6'd21, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(6'd42, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
    // weights of exact halves and of thirds that must round
    send_sample(6'd5, 16'd3, 32'd1, 32'd1);
    send_sample(6'd5, 16'd4, 32'd2, 32'd1);
    send_sample(6'd5, 16'd4, 32'd3, 32'd3);
    send_sample(6'd5, 16'd5, 32'd1, 32'd2);
    // near-constant count, variance rounding close to zero
    send_sample(6'd7, 16'd1, 32'd0, 32'd1);
    send_sample(6'd7, 16'd1, 32'd1, 32'd2);
    send_sample(6'd7, 16'd2, 32'd3, 32'h0000_8000);
    send_sample(6'd7, 16'd1, 32'h0000_8003, 32'd7);
    directed_items = 20;
  endtask

  task run_random();
    int                n;
    int                kind;
    bit [IDX_W-1:0]    idx;
    bit [CNT_IN_W-1:0] cnt;
    bit [TIME_W-1:0]   step;
    for (int i = 0; i < ENTRIES; i++) begin
      clock_of[i] = '0;
      level_of[i] = CNT_IN_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 27;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long hold-offs on the result side while words keep coming
      if (n == 30 || n == 2 * RANDOM_ITEMS / 3 + 20) hold_requests++;
      kind = $urandom_range(0, 99);
      idx  = (kind < 45) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom_range(0, ENTRIES - 1));
      if (kind < 80) begin
        // a proper history: elapsed time grows by each step taken
        step = $urandom_range(1, 32'h0004_0000);
        if (64'(clock_of[idx]) + 64'(step) > 64'hFFFF_FFFF) clock_of[idx] = '0;
        cnt = level_of[idx] + CNT_IN_W'($urandom_range(0, 1 << $urandom_range(0, 12)));
        if ($urandom_range(0, 9) == 0) level_of[idx] = CNT_IN_W'($urandom_range(0, 65535));
        send_sample(idx, cnt, clock_of[idx], step);
        clock_of[idx] += step;
      end else if (kind < 86) begin
        send_sample(idx, CNT_IN_W'($urandom), 32'd0, 32'd0);
      end else if (kind < 92) begin
        send_sample(idx, CNT_IN_W'($urandom), $urandom, $urandom_range(0, 255));
      end else begin
        send_sample(IDX_W'($urandom), CNT_IN_W'($urandom), $urandom, $urandom);
      end
    end
    sample_if.valid <= 1'b0;
  endtask

  initial begin
    rst                      <= 1'b1;
    sample_if.valid          <= 1'b0;
    sample_if.entry_index    <= '0;
    sample_if.sample_count   <= '0;
    sample_if.elapsed_before <= '0;
    sample_if.time_step      <= '0;
    send_idle_pct = 27;
    recv_idle_pct = 53;
    hold_requests = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_fault($sformatf("%0d results never arrived", sb.pending()));
    $display("run: %0d words sent (%0d hand-picked), %0d results compared, %0d zero total time",
             sb.samples, directed_items, sb.checked, sb.zero_hits);
    $display("idle mixes 27/53, 53/27 and none; %0d result hold-offs of %0d cycles; %0d faults",
             holds_done, HOLD_CYCLES, sb.faults);
    if (sb.faults == 0) begin
      $display("time_weighted_mean_variance verification clean");
    end else begin
      $display("time_weighted_mean_variance verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("time_weighted_mean_variance verification failed");
    $finish;
  end

endmodule
